// ===== hdl/bfa_pkg.sv =====
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types and constants of the bitmap frame allocator: field widths,
// beat layouts, request codes and the controller state type.
// ----------------------------------------------------------------------------
`default_nettype none

package bfa_pkg;

    // Default sizing of the used-frame bitmap
    localparam int DEF_MAX_FRAMES    = 32768;
    localparam int DEF_BITS_PER_WORD = 32;

    // Field widths
    localparam int PAGE_FRAME_W = 15;
    localparam int NUM_FRAMES_W = 16;

    localparam logic [NUM_FRAMES_W-1:0] NUM_FRAMES_RESET = 16'd32768;

    // Input beat: tdata = {pad, writable_page, kernel_page, page_frame}
    localparam int S_TDATA_W    = 24;
    localparam int IN_KERNEL_B  = 15;
    localparam int IN_WRITE_B   = 16;

    // Result beat: tdata = {pad, out_of_frames, newly_allocated, user_bit,
    //                       rw_bit, present_bit, frame_number}
    localparam int M_TDATA_W    = 24;
    localparam int OUT_PRESENT_B = 15;
    localparam int OUT_RW_B      = 16;
    localparam int OUT_USER_B    = 17;
    localparam int OUT_NEW_B     = 18;
    localparam int OUT_OOF_B     = 19;

    // Request codes carried in s_tuser
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FREE_DIV,
        ST_FREE_RD,
        ST_FREE_WR,
        ST_RESP
    } bfa_state_t;

endpackage : bfa_pkg

`default_nettype wire

// ===== hdl/bitmap_frame_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_frame_allocator
// First-fit physical frame allocator built around a used-frame bitmap held
// in a single-port-write, registered-read memory.
// ----------------------------------------------------------------------------
// One request is handled at a time. An allocate for a page that already
// holds a frame answers without touching the bitmap. An allocate for an
// empty page walks the bitmap one word per cycle from word 0, up to and
// including the word that decides the outcome (at most MAP_WORDS words,
// that is MAX_FRAMES/BITS_PER_WORD rounded up); the registered read of the
// bitmap memory is hidden by issuing the next word's read while the
// current one is examined. A free takes a reciprocal multiply that splits
// the frame number into word and bit, then one read and one write-back. A
// free of frame 0, or of a frame beyond the bitmap, answers without
// touching the bitmap. There is no clearing pass after reset: a fill count
// marks how many words from the bottom have ever been written by an
// allocation, and words at or above it read as all free, so the block is
// ready straight out of reset. Results wait in an output register, and a new
// request is taken while the previous result still waits to be collected.
// The num_frames register may only be written while the block is idle.
`default_nettype none

module bitmap_frame_allocator #(
    parameter int MAX_FRAMES    = bfa_pkg::DEF_MAX_FRAMES,
    parameter int BITS_PER_WORD = bfa_pkg::DEF_BITS_PER_WORD
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    // Configuration: num_frames
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [bfa_pkg::NUM_FRAMES_W-1:0]  cfg_data,

    // Requests
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [14:0] page_frame, [15] kernel_page, [16] writable_page, rest zero
    input  wire logic [bfa_pkg::S_TDATA_W-1:0]     s_tdata,
    // [0] command (0 allocate, 1 free)
    input  wire logic [0:0]                        s_tuser,

    // Results
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [14:0] frame_number, [15] present_bit, [16] rw_bit, [17] user_bit,
    // [18] newly_allocated, [19] out_of_frames, rest zero
    output logic [bfa_pkg::M_TDATA_W-1:0]          m_tdata
);
    import bfa_pkg::*;

    // ------------------------------------------------------------------
    // Derived sizes
    // ------------------------------------------------------------------
    localparam int MAP_WORDS = (MAX_FRAMES + BITS_PER_WORD - 1) / BITS_PER_WORD;
    localparam int IDX_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int FILL_W    = $clog2(MAP_WORDS + 1);
    localparam int BIT_W     = $clog2(BITS_PER_WORD);
    localparam int SPAN      = MAP_WORDS * BITS_PER_WORD;
    localparam int CAND_W    = $clog2(SPAN + 1);
    localparam int CMP_W     = (CAND_W > NUM_FRAMES_W) ? CAND_W : NUM_FRAMES_W;

    // Division of a page frame by BITS_PER_WORD through a reciprocal: with
    // the shift below the rounded-up reciprocal is exact for every 15-bit
    // numerator.
    localparam int DIV_S   = PAGE_FRAME_W + BIT_W;
    localparam int DIV_M_W = DIV_S + 1;
    localparam int PROD_W  = PAGE_FRAME_W + DIV_M_W;
    localparam logic [DIV_M_W-1:0] DIV_M =
        DIV_M_W'((2**DIV_S + BITS_PER_WORD - 1) / BITS_PER_WORD);

    localparam logic [IDX_W-1:0]  LAST_WORD = IDX_W'(MAP_WORDS - 1);
    localparam logic [CMP_W-1:0]  MAX_CMP   = CMP_W'(MAX_FRAMES);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    bfa_state_t                 state_reg, state_next;
    logic [NUM_FRAMES_W-1:0]    num_frames_reg, num_frames_next;
    logic [FILL_W-1:0]          fill_reg, fill_next;
    logic                       m_tvalid_reg, m_tvalid_next;
    logic                       chk_valid_reg, chk_valid_next;

    logic [M_TDATA_W-1:0]       m_tdata_reg, m_tdata_next;
    logic [M_TDATA_W-1:0]       res_reg, res_next;
    logic [PAGE_FRAME_W-1:0]    pf_reg, pf_next;
    logic                       kernel_reg, kernel_next;
    logic                       writable_reg, writable_next;
    logic [IDX_W-1:0]           issue_ptr_reg, issue_ptr_next;
    logic [CAND_W-1:0]          issue_base_reg, issue_base_next;
    logic [IDX_W-1:0]           chk_word_reg, chk_word_next;
    logic [CAND_W-1:0]          chk_base_reg, chk_base_next;
    logic [IDX_W-1:0]           quot_reg, quot_next;
    logic [BIT_W-1:0]           bitsel_reg, bitsel_next;

    // ------------------------------------------------------------------
    // Bitmap memory: one write port, one registered read port
    // ------------------------------------------------------------------
    logic [BITS_PER_WORD-1:0]   used_map [MAP_WORDS];
    logic [BITS_PER_WORD-1:0]   rdata_reg;
    logic                       mem_re, mem_we;
    logic [IDX_W-1:0]           mem_raddr, mem_waddr;
    logic [BITS_PER_WORD-1:0]   mem_wdata;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            used_map[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= used_map[mem_raddr];
        end
    end

    // ------------------------------------------------------------------
    // Examination of the word just read
    // ------------------------------------------------------------------
    logic                       in_accept, cfg_accept;
    logic                       req_cmd;
    logic [PAGE_FRAME_W-1:0]    req_pf;
    logic                       free_ok;
    logic [IDX_W-1:0]           rd_word;
    logic [BITS_PER_WORD-1:0]   rdata_eff;
    logic [BITS_PER_WORD-1:0]   low_clear;
    logic [BIT_W-1:0]           bit_idx;
    logic [CAND_W-1:0]          cand;
    logic [CMP_W-1:0]           limit;
    logic [CMP_W-1:0]           next_base;
    logic                       word_full, scan_hit, scan_more, scan_miss;
    logic [PROD_W-1:0]          quot_prod;
    logic [PAGE_FRAME_W-1:0]    rem;

    assign in_accept  = s_tvalid && s_tready;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign req_cmd    = s_tuser[0];
    assign req_pf     = s_tdata[PAGE_FRAME_W-1:0];
    assign free_ok    = (req_pf != '0) && (CMP_W'(req_pf) < MAX_CMP);

    // Words at or above the fill count never took an allocation and hold no frame.
    assign rd_word   = (state_reg == ST_FREE_WR) ? quot_reg : chk_word_reg;
    assign rdata_eff = (FILL_W'(rd_word) < fill_reg) ? rdata_reg : '0;

    // Isolate the lowest clear bit, then encode its position.
    assign word_full = &rdata_eff;
    assign low_clear = ~rdata_eff & (rdata_eff + BITS_PER_WORD'(1));

    always_comb begin
        bit_idx = '0;
        for (int j = 0; j < BIT_W; j++) begin
            for (int i = 0; i < BITS_PER_WORD; i++) begin
                if (i[j]) begin
                    bit_idx[j] = bit_idx[j] | low_clear[i];
                end
            end
        end
    end

    assign cand      = chk_base_reg + CAND_W'(bit_idx);
    assign limit     = (CMP_W'(num_frames_reg) > MAX_CMP) ? MAX_CMP
                                                          : CMP_W'(num_frames_reg);
    assign next_base = CMP_W'(chk_base_reg) + CMP_W'(BITS_PER_WORD);

    assign scan_hit  = chk_valid_reg && !word_full && (CMP_W'(cand) < limit);
    assign scan_more = chk_valid_reg && word_full && (next_base < limit)
                       && (chk_word_reg != LAST_WORD);
    assign scan_miss = chk_valid_reg && !scan_hit && !scan_more;

    assign quot_prod = PROD_W'(pf_reg) * PROD_W'(DIV_M);
    assign rem       = pf_reg - PAGE_FRAME_W'(quot_reg) * PAGE_FRAME_W'(BITS_PER_WORD);

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    if (req_cmd == CMD_FREE) begin
                        state_next = free_ok ? ST_FREE_DIV : ST_RESP;
                    end else begin
                        state_next = (req_pf == '0) ? ST_SCAN : ST_RESP;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_hit || scan_miss) begin
                    state_next = ST_RESP;
                end
            end
            ST_FREE_DIV: state_next = ST_FREE_RD;
            ST_FREE_RD:  state_next = ST_FREE_WR;
            ST_FREE_WR:  state_next = ST_RESP;
            ST_RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and memory control
    // ------------------------------------------------------------------
    always_comb begin
        num_frames_next = cfg_accept ? cfg_data : num_frames_reg;
        fill_next       = fill_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        chk_valid_next  = 1'b0;
        res_next        = res_reg;
        pf_next         = pf_reg;
        kernel_next     = kernel_reg;
        writable_next   = writable_reg;
        issue_ptr_next  = issue_ptr_reg;
        issue_base_next = issue_base_reg;
        chk_word_next   = chk_word_reg;
        chk_base_next   = chk_base_reg;
        quot_next       = quot_reg;
        bitsel_next     = bitsel_reg;
        mem_re          = 1'b0;
        mem_we          = 1'b0;
        mem_raddr       = issue_ptr_reg;
        mem_waddr       = chk_word_reg;
        mem_wdata       = rdata_eff | low_clear;

        unique case (state_reg)
            ST_IDLE: begin
                issue_ptr_next  = '0;
                issue_base_next = '0;
                if (in_accept) begin
                    pf_next       = req_pf;
                    kernel_next   = s_tdata[IN_KERNEL_B];
                    writable_next = s_tdata[IN_WRITE_B];
                    // Held frame or free: the answer is known now.
                    res_next      = '0;
                    if (req_cmd == CMD_ALLOC) begin
                        res_next[PAGE_FRAME_W-1:0] = req_pf;
                    end
                end
            end
            ST_SCAN: begin
                // Keep one read in flight ahead of the word being examined.
                if (issue_ptr_reg <= LAST_WORD) begin
                    mem_re          = 1'b1;
                    mem_raddr       = issue_ptr_reg;
                    issue_ptr_next  = issue_ptr_reg + IDX_W'(1);
                    issue_base_next = issue_base_reg + CAND_W'(BITS_PER_WORD);
                    chk_valid_next  = 1'b1;
                    chk_word_next   = issue_ptr_reg;
                    chk_base_next   = issue_base_reg;
                end
                if (scan_hit) begin
                    mem_we    = 1'b1;
                    mem_waddr = chk_word_reg;
                    mem_wdata = rdata_eff | low_clear;
                    if (FILL_W'(chk_word_reg) >= fill_reg) begin
                        fill_next = FILL_W'(chk_word_reg) + FILL_W'(1);
                    end
                    res_next                   = '0;
                    res_next[PAGE_FRAME_W-1:0] = PAGE_FRAME_W'(cand);
                    res_next[OUT_PRESENT_B]    = 1'b1;
                    res_next[OUT_RW_B]         = writable_reg;
                    res_next[OUT_USER_B]       = ~kernel_reg;
                    res_next[OUT_NEW_B]        = 1'b1;
                end else if (scan_miss) begin
                    res_next             = '0;
                    res_next[OUT_OOF_B]  = 1'b1;
                end
            end
            ST_FREE_DIV: begin
                quot_next = IDX_W'(quot_prod >> DIV_S);
            end
            ST_FREE_RD: begin
                mem_re      = 1'b1;
                mem_raddr   = quot_reg;
                bitsel_next = BIT_W'(rem);
            end
            ST_FREE_WR: begin
                mem_we    = 1'b1;
                mem_waddr = quot_reg;
                mem_wdata = rdata_eff & ~(BITS_PER_WORD'(1) << bitsel_reg);
            end
            ST_RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = res_reg;
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            num_frames_reg <= NUM_FRAMES_RESET;
            fill_reg       <= '0;
            m_tvalid_reg   <= 1'b0;
            chk_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            num_frames_reg <= num_frames_next;
            fill_reg       <= fill_next;
            m_tvalid_reg   <= m_tvalid_next;
            chk_valid_reg  <= chk_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg    <= m_tdata_next;
        res_reg        <= res_next;
        pf_reg         <= pf_next;
        kernel_reg     <= kernel_next;
        writable_reg   <= writable_next;
        issue_ptr_reg  <= issue_ptr_next;
        issue_base_reg <= issue_base_next;
        chk_word_reg   <= chk_word_next;
        chk_base_reg   <= chk_base_next;
        quot_reg       <= quot_next;
        bitsel_reg     <= bitsel_next;
    end

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // The bitmap is only written while scanning or finishing a free.
    assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == ST_SCAN || state_reg == ST_FREE_WR))
    else $error("bitmap written outside scan or free write-back");

    // An allocation sets exactly one new bit in the word it writes back.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && mem_we) |-> $onehot(mem_wdata ^ rdata_eff))
    else $error("allocation write-back does not set exactly one bit");

    // After an allocation the fill count covers the word that was written.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && mem_we) |=> (FILL_W'($past(chk_word_reg)) < fill_reg))
    else $error("fill count does not cover an allocated word");

    // A result beat is only raised from the response state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == ST_RESP))
    else $error("result raised outside the response state");

    // The fill count never runs past the end of the bitmap.
    assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(MAP_WORDS))
    else $error("fill count beyond bitmap depth");

endmodule : bitmap_frame_allocator

`default_nettype wire
